>>> rtl/core/connection_innovation_table_core_assert.svh
// Assertion helpers shared by the table core RTL.
// Every check is clocked on clk and masked while arst_n is low.
`ifndef CONNECTION_INNOVATION_TABLE_CORE_ASSERT_SVH
`define CONNECTION_INNOVATION_TABLE_CORE_ASSERT_SVH

// Same-cycle implication.
`define CIT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the next cycle.
`define CIT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/cit_pkg.sv
package cit_pkg;

	// Port widths
	localparam int REQ_W      = 2;
	localparam int NODE_W     = 16;
	localparam int NUM_W      = 32;
	localparam int STAT_W     = 2;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 32;

	// Parameter defaults
	localparam int DEF_TABLE_DEPTH = 64;
	localparam int DEF_NODE_BITS   = 16;
	localparam int DEF_NUMBER_BITS = 32;

	typedef enum logic [REQ_W-1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_TAKE   = 2'd2,
		REQ_FLUSH  = 2'd3
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_DUP  = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_SCAN,
		CS_FINISH
	} ctl_state_t;

	// Controller -> datapath
	typedef struct packed {
		logic load;    // latch request, restart scan
		logic scan;    // walk the table
		logic commit;  // update state, load result register
	} ctl_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic scan_done;
		logic out_free;
	} dp_stat_t;

endpackage

>>> rtl/core/cit_ctrl.sv
module cit_ctrl
	import cit_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_stat_t   dp_stat,
	output ctl_cmd_t   cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (in_valid) state_d = CS_SCAN;
			end
			CS_SCAN: begin
				if (dp_stat.scan_done) state_d = CS_FINISH;
			end
			CS_FINISH: begin
				if (dp_stat.out_free) state_d = CS_IDLE;
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			CS_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			CS_SCAN: begin
				cmd.scan = 1'b1;
			end
			CS_FINISH: begin
				cmd.commit = dp_stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> rtl/core/cit_dpath.sv
`include "connection_innovation_table_core_assert.svh"

module cit_dpath
	import cit_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int NODE_BITS   = DEF_NODE_BITS,
	parameter int NUMBER_BITS = DEF_NUMBER_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_cmd_t              cmd,
	output dp_stat_t              dp_stat,
	input  logic                  cfg_load,
	input  logic [CFG_DATA_W-1:0] cfg_value,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [NODE_W-1:0]     node_from,
	input  logic [NODE_W-1:0]     node_to,
	input  logic [NUM_W-1:0]      innovation_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  found,
	output logic [NUM_W-1:0]      innovation_out,
	output logic [STAT_W-1:0]     status
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = 2 * NODE_BITS + NUMBER_BITS;

	// Entry layout: {from, to, number}
	logic [EW-1:0] mem [TABLE_DEPTH];

	req_t                   req_q;
	logic [NODE_BITS-1:0]   from_q;
	logic [NODE_BITS-1:0]   to_q;
	logic [NUMBER_BITS-1:0] value_q;

	logic [CW-1:0]          count_q;
	logic [NUMBER_BITS-1:0] counter_q;
	logic [CW-1:0]          idx_q;
	logic                   rd_valid_s1;
	logic [EW-1:0]          rd_data_s1;
	logic                   hit_q;
	logic [NUMBER_BITS-1:0] hit_num_q;

	logic                   out_valid_q;
	logic                   found_q;
	logic [NUM_W-1:0]       num_out_q;
	stat_t                  status_q;

	logic                   need_scan;
	logic                   match;
	logic                   issue;
	logic                   room;
	logic                   mem_we;
	logic                   res_found;
	logic [NUMBER_BITS-1:0] res_num;
	stat_t                  res_status;

	assign need_scan = (req_q == REQ_LOOKUP) || (req_q == REQ_INSERT);
	assign match = rd_valid_s1
		&& (rd_data_s1[EW-1 -: NODE_BITS] == from_q)
		&& (rd_data_s1[NUMBER_BITS +: NODE_BITS] == to_q);
	// One read in flight; a match stops further reads so the first hit wins.
	assign issue = cmd.scan && need_scan && !hit_q && !match && (idx_q < count_q);
	assign room = count_q < CW'(TABLE_DEPTH);
	assign mem_we = cmd.commit && (req_q == REQ_INSERT) && !hit_q && room;

	assign dp_stat.scan_done = !need_scan || (!rd_valid_s1 && (hit_q || (idx_q >= count_q)));
	assign dp_stat.out_free  = !out_valid_q || !out_stall;

	always_comb begin
		res_found  = 1'b0;
		res_num    = '0;
		res_status = STAT_OK;
		case (req_q)
			REQ_LOOKUP: begin
				res_found = hit_q;
				if (hit_q) res_num = hit_num_q;
			end
			REQ_INSERT: begin
				if (hit_q) begin
					res_found  = 1'b1;
					res_status = STAT_DUP;
				end else if (!room) begin
					res_status = STAT_FULL;
				end
			end
			REQ_TAKE: begin
				res_num = counter_q;
			end
			default: begin
				res_num = '0;
			end
		endcase
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_t'(req_type);
			from_q  <= NODE_BITS'(node_from);
			to_q    <= NODE_BITS'(node_to);
			value_q <= NUMBER_BITS'(innovation_value);
		end
	end

	// Table storage, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[count_q[AW-1:0]] <= {from_q, to_q, value_q};
		if (issue) rd_data_s1 <= mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			hit_q       <= 1'b0;
		end else if (cmd.load) begin
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (issue) idx_q <= idx_q + 1'b1;
			if (match) hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (match) hit_num_q <= rd_data_s1[NUMBER_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			counter_q <= '0;
		end else begin
			if (cfg_load) begin
				counter_q <= NUMBER_BITS'(cfg_value);
			end else if (cmd.commit && (req_q == REQ_TAKE)) begin
				counter_q <= counter_q + 1'b1;
			end
			if (cmd.commit && (req_q == REQ_FLUSH)) begin
				count_q <= '0;
			end else if (mem_we) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			found_q   <= res_found;
			num_out_q <= NUM_W'(res_num);
			status_q  <= res_status;
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign innovation_out = num_out_q;
	assign status         = status_q;

	`CIT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(TABLE_DEPTH), "entry count past depth")
	`CIT_ASSERT_NOW(a_no_read_after_hit, hit_q, !rd_valid_s1, "table read after a hit")
	`CIT_ASSERT_NOW(a_commit_slot_free, cmd.commit, !out_valid_q || !out_stall, "result overrun")
	`CIT_ASSERT_NEXT(a_insert_grows, mem_we, count_q == $past(count_q) + 1'b1, "insert lost")

endmodule

>>> rtl/core/connection_innovation_table_core.sv
// Lookup and insert: the transfer loads the request register, then the scan
//   reads entries in insertion order (reads = entries compared: count on a miss,
//   k+1 for a hit at entry k; none on an empty table) and the finish state commits the result.
// Take-next and flush read no entry; the finish state commits their result.
// Throughput: one request in flight; the single table read port sets the pace,
//   one entry a cycle, so a lookup or insert takes longer as the table fills.
// Reset (arst_n low): table empty, counter and start_number 0, no result pending.
module connection_innovation_table_core
	import cit_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int NODE_BITS   = DEF_NODE_BITS,
	parameter int NUMBER_BITS = DEF_NUMBER_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [NODE_W-1:0]     node_from,
	input  logic [NODE_W-1:0]     node_to,
	input  logic [NUM_W-1:0]      innovation_value,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  found,
	output logic [NUM_W-1:0]      innovation_out,
	output logic [STAT_W-1:0]     status,
	// register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	// Only one register (start_number, offset 0); every byte offset of the
	// word decodes to it, so paddr does not take part in the decode.
	logic                  cfg_wr;
	logic [CFG_DATA_W-1:0] start_q;
	logic [CFG_ADDR_W-1:0] paddr_unused;

	ctl_cmd_t cmd;
	dp_stat_t dp_stat;

	assign pready       = 1'b1;
	assign cfg_wr       = psel && penable && pwrite;
	assign paddr_unused = paddr;
	assign prdata       = start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (cfg_wr) begin
			start_q <= pwdata;
		end
	end

	// Sequencer: idle -> scan -> finish. A new transfer is taken as soon as
	// the previous result sits in the output register, even if it is stalled.
	cit_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.dp_stat  (dp_stat),
		.cmd      (cmd)
	);

	// Table memory, scan compare, counters and result register.
	// A start_number write also loads the innovation counter.
	cit_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.NODE_BITS   (NODE_BITS),
		.NUMBER_BITS (NUMBER_BITS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.dp_stat          (dp_stat),
		.cfg_load         (cfg_wr && (paddr_unused == paddr)),
		.cfg_value        (pwdata),
		.req_type         (req_type),
		.node_from        (node_from),
		.node_to          (node_to),
		.innovation_value (innovation_value),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.found            (found),
		.innovation_out   (innovation_out),
		.status           (status)
	);

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import cit_pkg::*;

	localparam int TABLE_DEPTH  = DEF_TABLE_DEPTH;
	localparam int RANDOM_ITEMS = 1500;
	// last stretch of the random part runs with no idling on either side
	localparam int QUIET_ITEMS  = 200;
	// worst scan: full table plus pipeline overhead
	localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam logic [CFG_ADDR_W-1:0] ADDR_START_NUMBER = '0;

	typedef struct packed {
		logic             found;
		logic [NUM_W-1:0] number;
		stat_t            status;
	} table_result_t;

	// one row of the directed script; typed rows carry their own expectation
	typedef struct {
		logic              is_cfg;
		req_t              kind;
		logic [NODE_W-1:0] src;
		logic [NODE_W-1:0] dst;
		logic [NUM_W-1:0]  value;
		logic              typed;
		logic              found;
		logic [NUM_W-1:0]  number;
		stat_t             status;
	} script_row_t;

	logic                  clk              = 1'b0;
	logic                  arst_n           = 1'b0;
	logic                  in_valid         = 1'b0;
	logic                  in_stall;
	logic [REQ_W-1:0]      req_type         = '0;
	logic [NODE_W-1:0]     node_from        = '0;
	logic [NODE_W-1:0]     node_to          = '0;
	logic [NUM_W-1:0]      innovation_value = '0;
	logic                  out_valid;
	logic                  out_stall        = 1'b0;
	logic                  found;
	logic [NUM_W-1:0]      innovation_out;
	logic [STAT_W-1:0]     status;
	logic                  psel             = 1'b0;
	logic                  penable          = 1'b0;
	logic                  pwrite           = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr            = '0;
	logic [CFG_DATA_W-1:0] pwdata           = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	// shadow copy of the table, its fill level and the innovation counter
	logic [NODE_W-1:0] mdl_from [TABLE_DEPTH];
	logic [NODE_W-1:0] mdl_to   [TABLE_DEPTH];
	logic [NUM_W-1:0]  mdl_num  [TABLE_DEPTH];
	int                mdl_count   = 0;
	logic [NUM_W-1:0]  mdl_counter = '0;

	table_result_t pending_results [$];
	script_row_t   script [$];
	int            errors      = 0;
	int            cycles      = 0;
	int            items_sent  = 0;
	bit            quiet       = 1'b0;
	int            stall_left  = 0;
	table_result_t want;

	connection_innovation_table_core u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.req_type         (req_type),
		.node_from        (node_from),
		.node_to          (node_to),
		.innovation_value (innovation_value),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.found            (found),
		.innovation_out   (innovation_out),
		.status           (status),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Result-side backpressure: bursts of stall or no stall of random length,
	// stall chosen one time in three; forced off during the quiet tail.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_left <= $urandom_range(1, 15);
			out_stall  <= ($urandom_range(0, 2) == 0);
		end
	end

	// Predict one request and update the shadow state.
	// Scan is in insertion order; first match wins.
	function automatic table_result_t resolve_request(input req_t kind,
			input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst,
			input logic [NUM_W-1:0] value);
		table_result_t res;
		int hit;
		int i;
		res.found  = 1'b0;
		res.number = '0;
		res.status = STAT_OK;
		hit = -1;
		for (i = 0; i < mdl_count; i++) begin
			if (hit < 0 && mdl_from[i] == src && mdl_to[i] == dst)
				hit = i;
		end
		case (kind)
			REQ_LOOKUP: begin
				if (hit >= 0) begin
					res.found  = 1'b1;
					res.number = mdl_num[hit];
				end
			end
			REQ_INSERT: begin
				// duplicate wins over table full
				if (hit >= 0) begin
					res.found  = 1'b1;
					res.status = STAT_DUP;
				end else if (mdl_count >= TABLE_DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					mdl_from[mdl_count] = src;
					mdl_to[mdl_count]   = dst;
					mdl_num[mdl_count]  = value;
					mdl_count++;
				end
			end
			REQ_TAKE: begin
				res.number  = mdl_counter;
				mdl_counter = mdl_counter + 1'b1;	// wraps at all-ones
			end
			default: begin
				mdl_count = 0;	// flush keeps the counter
			end
		endcase
		return res;
	endfunction

	// Result checker: every transfer on the result side against the oldest
	// pending expectation, field by field.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result found=%0d number=%h status=%0d",
					$time, found, innovation_out, status);
			end else begin
				want = pending_results.pop_front();
				if (found !== want.found) begin
					errors++;
					$display("%0t: found expected %0d actual %0d", $time, want.found, found);
				end
				if (innovation_out !== want.number) begin
					errors++;
					$display("%0t: innovation_out expected %h actual %h",
						$time, want.number, innovation_out);
				end
				if (status !== want.status) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
				end
			end
		end
	end

	task automatic drain_results();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Present one request, hold it through stalls, record the expectation at
	// the accepting edge. Returns in the time step of that edge with
	// in_valid still high so back-to-back transfers need no toggle.
	task automatic issue(input req_t kind, input logic [NODE_W-1:0] src,
			input logic [NODE_W-1:0] dst, input logic [NUM_W-1:0] value,
			input logic typed, input logic t_found, input logic [NUM_W-1:0] t_num,
			input stat_t t_stat);
		table_result_t res;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid         <= 1'b1;
		req_type         <= kind;
		node_from        <= src;
		node_to          <= dst;
		innovation_value <= value;
		do @(posedge clk); while (in_stall);
		res = resolve_request(kind, src, dst, value);
		if (typed) begin
			res.found  = t_found;
			res.number = t_num;
			res.status = t_stat;
		end
		pending_results.push_back(res);
		items_sent++;
	endtask

	// Register write only with the block idle, then read it back.
	task automatic write_start_number(input logic [CFG_DATA_W-1:0] data);
		in_valid <= 1'b0;
		drain_results();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_START_NUMBER;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		mdl_counter = data;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== data) begin
			errors++;
			$display("%0t: start_number readback expected %h actual %h", $time, data, prdata);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic add_row(input logic is_cfg, input req_t kind,
			input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst,
			input logic [NUM_W-1:0] value, input logic typed, input logic t_found,
			input logic [NUM_W-1:0] t_num, input stat_t t_stat);
		script_row_t row;
		row.is_cfg = is_cfg;
		row.kind   = kind;
		row.src    = src;
		row.dst    = dst;
		row.value  = value;
		row.typed  = typed;
		row.found  = t_found;
		row.number = t_num;
		row.status = t_stat;
		script.push_back(row);
	endtask

	// Pair source for random traffic: stored pairs (hits at any depth),
	// a tiny pool (collisions), full range, or corner ids.
	task automatic choose_pair(output logic [NODE_W-1:0] src, output logic [NODE_W-1:0] dst);
		int idx;
		case ($urandom_range(0, 3))
			0: begin
				if (mdl_count != 0) begin
					idx = $urandom_range(0, mdl_count - 1);
					src = mdl_from[idx];
					dst = mdl_to[idx];
				end else begin
					src = NODE_W'($urandom_range(0, 3));
					dst = NODE_W'($urandom_range(0, 3));
				end
			end
			1: begin
				src = NODE_W'($urandom_range(0, 3));
				dst = NODE_W'($urandom_range(0, 3));
			end
			2: begin
				src = NODE_W'($urandom());
				dst = NODE_W'($urandom());
			end
			default: begin
				src = $urandom_range(0, 1) ? '1 : '0;
				dst = $urandom_range(0, 1) ? '1 : NODE_W'($urandom());
			end
		endcase
	endtask

	function automatic logic [NUM_W-1:0] random_number();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return NUM_W'($urandom());
		endcase
	endfunction

	initial begin
		int mode;
		int len;
		int pick;
		int random_base;
		logic [NODE_W-1:0] s;
		logic [NODE_W-1:0] d;
		req_t k;

		// Directed script: empty table, counter from reset, corner ids and
		// numbers, hits, misses, duplicate, flush, counter wrap.
		add_row(0, REQ_LOOKUP, 16'h0000, 16'h0000, 32'h0,        1, 0, 32'h0,        STAT_OK);
		add_row(0, REQ_TAKE,   16'h0000, 16'h0000, 32'h0,        1, 0, 32'h0,        STAT_OK);
		add_row(0, REQ_TAKE,   16'hffff, 16'hffff, 32'hffffffff, 1, 0, 32'h1,        STAT_OK);
		add_row(0, REQ_INSERT, 16'h0000, 16'h0000, 32'h0,        1, 0, 32'h0,        STAT_OK);
		add_row(0, REQ_INSERT, 16'hffff, 16'hffff, 32'hffffffff, 1, 0, 32'h0,        STAT_OK);
		add_row(0, REQ_LOOKUP, 16'hffff, 16'hffff, 32'h0,        1, 1, 32'hffffffff, STAT_OK);
		add_row(0, REQ_LOOKUP, 16'h0000, 16'h0000, 32'hffffffff, 1, 1, 32'h0,        STAT_OK);
		add_row(0, REQ_INSERT, 16'h0000, 16'h0000, 32'h5,        1, 1, 32'h0,        STAT_DUP);
		add_row(0, REQ_LOOKUP, 16'hffff, 16'h0000, 32'h0,        1, 0, 32'h0,        STAT_OK);
		add_row(0, REQ_LOOKUP, 16'h0000, 16'hffff, 32'h0,        1, 0, 32'h0,        STAT_OK);
		add_row(0, REQ_INSERT, 16'h1234, 16'h5678, 32'ha5a5a5a5, 0, 0, 32'h0,        STAT_OK);
		add_row(0, REQ_LOOKUP, 16'h1234, 16'h5678, 32'h0,        0, 0, 32'h0,        STAT_OK);
		add_row(0, REQ_FLUSH,  16'h0000, 16'h0000, 32'h0,        1, 0, 32'h0,        STAT_OK);
		add_row(0, REQ_LOOKUP, 16'hffff, 16'hffff, 32'h0,        1, 0, 32'h0,        STAT_OK);
		add_row(1, REQ_LOOKUP, 16'h0000, 16'h0000, 32'hffffffff, 0, 0, 32'h0,        STAT_OK);
		add_row(0, REQ_TAKE,   16'h0000, 16'h0000, 32'h0,        1, 0, 32'hffffffff, STAT_OK);
		add_row(0, REQ_TAKE,   16'h0000, 16'h0000, 32'h0,        1, 0, 32'h0,        STAT_OK);
		add_row(1, REQ_LOOKUP, 16'h0000, 16'h0000, 32'h0,        0, 0, 32'h0,        STAT_OK);
		add_row(0, REQ_TAKE,   16'h0000, 16'h0000, 32'h0,        1, 0, 32'h0,        STAT_OK);
		add_row(1, REQ_LOOKUP, 16'h0000, 16'h0000, 32'h80000000, 0, 0, 32'h0,        STAT_OK);
		add_row(0, REQ_TAKE,   16'h0000, 16'h0000, 32'h0,        0, 0, 32'h0,        STAT_OK);
		add_row(0, REQ_INSERT, 16'h5555, 16'haaaa, 32'h5a5a5a5a, 0, 0, 32'h0,        STAT_OK);
		// flush ignores its payload
		add_row(0, REQ_FLUSH,  16'h8001, 16'h7ffe, 32'h12345678, 1, 0, 32'h0,        STAT_OK);
		add_row(0, REQ_TAKE,   16'haaaa, 16'h5555, 32'hdeadbeef, 0, 0, 32'h0,        STAT_OK);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg)
				write_start_number(script[i].value);
			else
				issue(script[i].kind, script[i].src, script[i].dst, script[i].value,
					script[i].typed, script[i].found, script[i].number, script[i].status);
		end

		// Random part in bursts: fill runs that drive the table to full,
		// mixed traffic over colliding pairs, short noise, and idle points
		// for a register write or a plain drain (none in the quiet tail).
		random_base = items_sent;
		while (items_sent - random_base < RANDOM_ITEMS) begin
			quiet = (items_sent - random_base >= RANDOM_ITEMS - QUIET_ITEMS);
			mode  = quiet ? $urandom_range(1, 9) : $urandom_range(0, 9);
			if (mode == 0) begin
				if ($urandom_range(0, 1)) begin
					case ($urandom_range(0, 4))
						0:       write_start_number('0);
						1:       write_start_number('1);
						2:       write_start_number(32'hfffffffe);
						3:       write_start_number(32'h80000000);
						default: write_start_number($urandom());
					endcase
				end else begin
					// sender holds off until every result is back
					in_valid <= 1'b0;
					drain_results();
					@(posedge clk);
				end
			end else if (mode <= 3) begin
				if ($urandom_range(0, 1))
					issue(REQ_FLUSH, NODE_W'($urandom()), NODE_W'($urandom()), $urandom(),
						0, 0, '0, STAT_OK);
				len = $urandom_range(20, 80);
				repeat (len) begin
					pick = $urandom_range(0, 9);
					if (pick < 7) begin
						issue(REQ_INSERT, NODE_W'($urandom()), NODE_W'($urandom()),
							random_number(), 0, 0, '0, STAT_OK);
					end else if (pick < 9) begin
						choose_pair(s, d);
						issue(REQ_LOOKUP, s, d, random_number(), 0, 0, '0, STAT_OK);
					end else begin
						// mostly duplicates, some of them against a full table
						choose_pair(s, d);
						issue(REQ_INSERT, s, d, random_number(), 0, 0, '0, STAT_OK);
					end
				end
			end else if (mode <= 8) begin
				len = $urandom_range(8, 40);
				repeat (len) begin
					pick = $urandom_range(0, 99);
					if (pick < 40)
						k = REQ_LOOKUP;
					else if (pick < 75)
						k = REQ_INSERT;
					else if (pick < 97)
						k = REQ_TAKE;
					else
						k = REQ_FLUSH;
					choose_pair(s, d);
					issue(k, s, d, random_number(), 0, 0, '0, STAT_OK);
				end
			end else begin
				len = $urandom_range(3, 10);
				repeat (len)
					issue(req_t'($urandom_range(0, 3)), NODE_W'($urandom()),
						NODE_W'($urandom()), $urandom(), 0, 0, '0, STAT_OK);
			end
		end

		in_valid <= 1'b0;
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
